FILE: design/sktbl_pkg.sv
package sktbl_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OFFSET_W = 64;
  localparam int unsigned LENGTH_W = 32;
  localparam int unsigned FLAGS_W  = 32;
  localparam int unsigned COUNT_W  = 9;

  localparam int unsigned S_TDATA_W = 160;
  localparam int unsigned S_TUSER_W = OPCODE_W;
  localparam int unsigned M_TDATA_W = 144;
  localparam int unsigned M_TUSER_W = 2;

  localparam logic [OPCODE_W-1:0] OP_SET   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_GET   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [FLAGS_W-1:0]  flags;
  } entry_t;

  typedef struct packed {
    logic cmp;  // latch compare flags against the search key
    logic upd;  // overwrite the matching entry
    logic ins;  // insert new entry, shift larger keys up
  } cell_ctrl_t;

endpackage

FILE: design/sktbl_cell.sv
module sktbl_cell (
  input  logic                         clk_i,
  input  sktbl_pkg::cell_ctrl_t        ctrl_i,
  input  logic                         occ_i,
  input  logic [sktbl_pkg::KEY_W-1:0]  key_i,
  input  sktbl_pkg::entry_t            new_i,
  input  sktbl_pkg::entry_t            prev_i,
  input  logic                         prev_lt_i,
  output sktbl_pkg::entry_t            entry_o,
  output logic                         lt_o,
  output logic                         eq_o
);
  import sktbl_pkg::*;

  entry_t entry_q, entry_d;
  logic   lt_q, eq_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.upd && eq_q) begin
      entry_d.offset = new_i.offset;
      entry_d.length = new_i.length;
      entry_d.flags  = new_i.flags;
    end else if (ctrl_i.ins && !lt_q) begin
      entry_d = prev_lt_i ? new_i : prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.cmp) begin
      lt_q <= occ_i && (entry_q.key < key_i);
      eq_q <= occ_i && (entry_q.key == key_i);
    end
  end

  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

FILE: design/sorted_key_table_insert_lookup.sv
// An accepted input item is registered while all cells latch their compare flags; in the
//   execute state the cells shift or update and the result is registered for the master
//   side once the output register has room. No new item is taken until that happens.
// A waiting result does not block acceptance of the next item.
// Reset clears the entry count, state machine and output valid; table contents
//   are left undefined.
module sorted_key_table_insert_lookup #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // page_number[31:0], entry_offset[95:32], entry_length[127:96], entry_flags[159:128]
  input  logic [sktbl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [sktbl_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // found_offset[63:0], found_length[95:64], found_flags[127:96],
  // entry_count[136:128], zero fill [143:137]
  output logic [sktbl_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // status[0], hit[1]
  output logic [sktbl_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
  import sktbl_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;
  logic [M_TUSER_W-1:0] out_user_q, out_user_d;

  logic [OPCODE_W-1:0] op_q;
  entry_t              item_q, item_in;

  logic accept, fire, hit, full;
  cell_ctrl_t ctrl;
  entry_t found;

  entry_t            cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_lt, cell_eq, occ;

  assign item_in.key    = s_axis_tdata[31:0];
  assign item_in.offset = s_axis_tdata[95:32];
  assign item_in.length = s_axis_tdata[127:96];
  assign item_in.flags  = s_axis_tdata[159:128];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
  assign full          = (count_q == CW'(CAPACITY));

  always_comb begin
    hit   = 1'b0;
    found = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit   = hit | cell_eq[i];
      found = found | (cell_eq[i] ? cell_entry[i] : '0);
    end
  end

  assign ctrl.cmp = accept;
  assign ctrl.upd = fire && (op_q == OP_SET) && hit;
  assign ctrl.ins = fire && (op_q == OP_SET) && !hit && !full;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign occ[g] = count_q > CW'(g);
    if (g == 0) begin : g_head
      sktbl_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl),
        .occ_i     (occ[g]),
        .key_i     (item_in.key),
        .new_i     (item_q),
        .prev_i    (item_q),
        .prev_lt_i (1'b1),
        .entry_o   (cell_entry[g]),
        .lt_o      (cell_lt[g]),
        .eq_o      (cell_eq[g])
      );
    end else begin : g_body
      sktbl_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl),
        .occ_i     (occ[g]),
        .key_i     (item_in.key),
        .new_i     (item_q),
        .prev_i    (cell_entry[g-1]),
        .prev_lt_i (cell_lt[g-1]),
        .entry_o   (cell_entry[g]),
        .lt_o      (cell_lt[g]),
        .eq_o      (cell_eq[g])
      );
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_user_d  = '0;
          out_data_d  = '0;
          unique case (op_q)
            OP_SET: begin
              out_user_d[1] = hit;
              if (!hit) begin
                if (full) begin
                  out_user_d[0] = 1'b1;
                end else begin
                  count_d = count_q + CW'(1);
                end
              end
            end
            OP_GET: begin
              out_user_d[1] = hit;
              out_data_d[63:0]   = found.offset;
              out_data_d[95:64]  = found.length;
              out_data_d[127:96] = found.flags;
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
          out_data_d[136:128] = COUNT_W'(count_d);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    if (accept) begin
      op_q   <= s_axis_tuser;
      item_q <= item_in;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

FILE: tb/testbench.sv
module testbench;
  import sktbl_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned POOL_SIZE   = 40;
  localparam int unsigned LONG_HOLD   = 80;
  localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

  typedef logic [OPCODE_W-1:0] opcode_t;

  typedef struct packed {
    logic                status;
    logic                hit;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [FLAGS_W-1:0]  flags;
    logic [COUNT_W-1:0]  count;
  } lookup_result_t;

  // Mirror of the sorted table; one expected result per accepted item.
  class table_checker;
    entry_t         slots[TABLE_DEPTH];
    int unsigned    used;
    lookup_result_t due_results[$];
    int unsigned    errors;

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void note_request(opcode_t op, logic [S_TDATA_W-1:0] data);
      lookup_result_t res;
      entry_t         req;
      int unsigned    pos;
      bit             found;
      req.key    = data[31:0];
      req.offset = data[95:32];
      req.length = data[127:96];
      req.flags  = data[159:128];
      res = '0;
      pos = 0;
      while (pos < used && slots[pos].key < req.key) pos++;
      found = (pos < used) && (slots[pos].key == req.key);
      case (op)
        OP_SET: begin
          if (found) begin
            slots[pos] = req;
            res.hit = 1'b1;
          end else if (used >= TABLE_DEPTH) begin
            res.status = 1'b1;
          end else begin
            for (int i = used; i > int'(pos); i--) slots[i] = slots[i-1];
            slots[pos] = req;
            used++;
          end
        end
        OP_GET: begin
          if (found) begin
            res.hit    = 1'b1;
            res.offset = slots[pos].offset;
            res.length = slots[pos].length;
            res.flags  = slots[pos].flags;
          end
        end
        OP_CLEAR: begin
          used = 0;
        end
        default: begin
        end
      endcase
      res.count = COUNT_W'(used);
      due_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, seen);
      end
    endfunction

    function void check_response(logic [M_TUSER_W-1:0] user, logic [M_TDATA_W-1:0] data);
      lookup_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual tuser %h tdata %h",
                 $time, user, data);
        return;
      end
      want = due_results.pop_front();
      compare_field("status", want.status, user[0]);
      compare_field("hit", want.hit, user[1]);
      compare_field("found_offset", want.offset, data[63:0]);
      compare_field("found_length", want.length, data[95:64]);
      compare_field("found_flags", want.flags, data[127:96]);
      compare_field("entry_count", want.count, data[136:128]);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  table_checker tbl = new;
  bit           calm;
  bit           hold_req;
  logic [31:0]  key_pool[POOL_SIZE];

  sorted_key_table_insert_lookup #(
    .CAPACITY(TABLE_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) tbl.check_response(m_axis_tuser, m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) tbl.note_request(s_axis_tuser, s_axis_tdata);
    end
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(opcode_t op, logic [31:0] key, logic [63:0] off,
                           logic [31:0] len, logic [31:0] flg);
    int unsigned gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {flg, len, off, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tbl.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [31:0] key;
    opcode_t     op;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_SET;
    else if (pick < 92) op = OP_GET;
    else if (pick < 96) op = OP_CLEAR;
    else op = OP_NOP;
    if ($urandom_range(0, 4) == 0) key = $urandom;
    else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    send_item(op, key, {$urandom, $urandom}, $urandom, $urandom);
  endtask

  initial begin
    logic [31:0] fill_keys[TABLE_DEPTH];
    logic [31:0] swap;
    int unsigned j;
    calm          = 1'b0;
    hold_req      = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_SET;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    for (int i = 3; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty lookup, extremes, ordering, update, no-op, clear
    send_item(OP_GET, 32'h0000_0000, '0, '0, '0);
    send_item(OP_SET, 32'h8000_0000, '1, '1, '1);
    send_item(OP_SET, 32'h0000_0000, '0, '0, '0);
    send_item(OP_SET, 32'hFFFF_FFFF, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
              32'h5555_5555);
    send_item(OP_SET, 32'h0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555,
              32'hAAAA_AAAA);
    send_item(OP_GET, 32'h0000_0000, '1, '1, '1);
    send_item(OP_GET, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(OP_GET, 32'h8000_0000, '0, '0, '0);
    send_item(OP_GET, 32'h0000_0001, '0, '0, '0);
    send_item(OP_GET, 32'h0000_0002, '0, '0, '0);
    send_item(OP_GET, 32'h7FFF_FFFF, '0, '0, '0);
    send_item(OP_SET, 32'h8000_0000, 64'h0123_4567_89AB_CDEF, 32'h0000_0001,
              32'h8000_0000);
    send_item(OP_GET, 32'h8000_0000, '0, '0, '0);
    send_item(OP_NOP, 32'hFFFF_FFFF, '1, '1, '1);
    send_item(OP_NOP, 32'h0000_0000, '0, '0, '0);
    send_item(OP_CLEAR, 32'hFFFF_FFFF, '1, '1, '1);
    send_item(OP_GET, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(OP_SET, 32'h0000_0001, {$urandom, $urandom}, $urandom, $urandom);
    send_item(OP_GET, 32'h0000_0001, '0, '0, '0);
    send_item(OP_CLEAR, 32'h0, '0, '0, '0);
    wait_drained();

    // fill to capacity in shuffled order; keys avoid 0, all ones and multiples
    // of 2**24
    for (int i = 0; i < TABLE_DEPTH; i++)
      fill_keys[i] = (i << 24) | $urandom_range(1, 32'h00FF_FFFE);
    for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = fill_keys[i];
      fill_keys[i] = fill_keys[j];
      fill_keys[j] = swap;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_item(OP_SET, fill_keys[i], {$urandom, $urandom}, $urandom, $urandom);
      if ($urandom_range(0, 3) == 0)
        send_item(OP_GET, fill_keys[$urandom_range(0, i)], {$urandom, $urandom},
                  $urandom, $urandom);
    end
    // full table: new keys refused, present keys still updated
    send_item(OP_SET, 32'h0000_0000, '1, '1, '1);
    send_item(OP_SET, 32'hFFFF_FFFF, '1, '1, '1);
    send_item(OP_SET, 32'h0300_0000, {$urandom, $urandom}, $urandom, $urandom);
    send_item(OP_SET, fill_keys[5], {$urandom, $urandom}, $urandom, $urandom);
    send_item(OP_GET, fill_keys[5], '0, '0, '0);
    send_item(OP_GET, 32'h0000_0000, '0, '0, '0);
    send_item(OP_GET, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(OP_GET, fill_keys[0], '0, '0, '0);
    send_item(OP_GET, fill_keys[TABLE_DEPTH - 1], '0, '0, '0);
    send_item(OP_NOP, $urandom, {$urandom, $urandom}, $urandom, $urandom);
    send_item(OP_CLEAR, $urandom, {$urandom, $urandom}, $urandom, $urandom);
    send_item(OP_GET, fill_keys[5], '0, '0, '0);
    wait_drained();

    // random mix; receiver holds off for a long stretch early on
    hold_req = 1'b1;
    repeat (300) random_item();
    wait_drained();
    calm = 1'b1;
    repeat (100) random_item();

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (tbl.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
